@@ design/epge_pkg.sv @@
// Shared types, constants and the element operator of the PE grid evaluator.
package epge_pkg;

	localparam int FEATURES_DEF    = 16;
	localparam int PES_DEF         = 8;
	localparam int COLUMNS_DEF     = 8;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_ENABLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

	localparam logic [3:0] COLUMN_COUNT_RST = 4'd8;
	localparam logic [7:0] THRESHOLD_RST    = 8'd255;

	typedef enum logic {
		OP_GENE    = 1'b0,
		OP_FEATURE = 1'b1
	} operation_t;

	typedef enum logic {
		CMD_GENE    = 1'b0,
		CMD_FEATURE = 1'b1
	} cmd_kind_t;

	// one queued word: store write and/or evaluation trigger
	typedef struct packed {
		cmd_kind_t  kind;
		logic       wr;
		logic       eval;
		logic [7:0] addr;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		OPC_HALF_X = 3'd0,
		OPC_AVG    = 3'd1,
		OPC_SUM    = 3'd2,
		OPC_MAX    = 3'd3,
		OPC_MIN    = 3'd4,
		OPC_DBL_X  = 3'd5,
		OPC_DBL_Y  = 3'd6,
		OPC_HALF_Y = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GX,
		ST_GY,
		ST_GOP,
		ST_EXEC
	} seq_state_t;

	function automatic logic [7:0] apply_op(opcode_t op, logic [7:0] x, logic [7:0] y);
		logic [8:0] r;
		logic [8:0] w;
		case (op)
			OPC_HALF_X: r = {2'b00, x[7:1]};
			OPC_AVG:    r = ({1'b0, x} + {1'b0, y}) >> 1;
			OPC_SUM:    r = {1'b0, x} + {1'b0, y};
			OPC_MAX:    r = {1'b0, (x > y) ? x : y};
			OPC_MIN:    r = {1'b0, (x < y) ? x : y};
			OPC_DBL_X:  r = {x, 1'b0};
			OPC_DBL_Y:  r = {y, 1'b0};
			default:    r = {2'b00, y[7:1]};
		endcase
		// above 255: r mod 255, r never exceeds 510
		w = r - 9'd255;
		if (r > 9'd255) begin
			apply_op = (w == 9'd255) ? 8'd0 : w[7:0];
		end else begin
			apply_op = r[7:0];
		end
	endfunction

endpackage

@@ design/epge_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module epge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ design/epge_front.sv @@
// Front end: accepts input words, tracks the feature position, builds queue words.
module epge_front #(
	parameter int FEATURES   = epge_pkg::FEATURES_DEF,
	parameter int GENE_DEPTH = epge_pkg::COLUMNS_DEF * 3 * epge_pkg::PES_DEF + 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic            operation,
	input  logic [7:0]      gene_index,
	input  logic [3:0]      gene_value,
	input  logic [7:0]      feature_value,
	input  logic            last_feature,
	input  logic            q_full,
	output logic            q_push,
	output epge_pkg::cmd_t  q_word
);

	localparam int FP_W = $clog2(FEATURES + 1);

	logic [FP_W-1:0] pos_q;
	logic            accept;
	logic            is_feat;
	logic            room;

	assign busy    = q_full;
	assign accept  = start & ~q_full;
	assign is_feat = (operation == epge_pkg::OP_FEATURE);
	assign room    = (pos_q < FP_W'(FEATURES));

	always_comb begin
		q_word.kind = is_feat ? epge_pkg::CMD_FEATURE : epge_pkg::CMD_GENE;
		q_word.wr   = is_feat ? room : (int'(gene_index) < GENE_DEPTH);
		q_word.eval = is_feat & last_feature;
		q_word.addr = is_feat ? 8'(pos_q) : gene_index;
		q_word.data = is_feat ? feature_value : {4'b0000, gene_value};
	end

	assign q_push = accept & (q_word.wr | q_word.eval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && is_feat) begin
			if (last_feature) begin
				pos_q <= '0;
			end else if (room) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

@@ design/epge_queue.sv @@
// Short word queue between front end and evaluation engine.
module epge_queue #(
	parameter int DEPTH = epge_pkg::QUEUE_DEPTH,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  epge_pkg::cmd_t push_word,
	output logic           full,
	input  logic           pop,
	output epge_pkg::cmd_t pop_word,
	output logic           empty
);

	epge_pkg::cmd_t  slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == (PW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_word = slot_q[rd_ptr_q];
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/epge_back.sv @@
// Evaluation engine: executes queued store writes and steps through the grid.
module epge_back #(
	parameter int FEATURES       = epge_pkg::FEATURES_DEF,
	parameter int PES_PER_COLUMN = epge_pkg::PES_DEF,
	parameter int COLUMNS        = epge_pkg::COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  epge_pkg::cmd_t pop_word,
	input  logic           empty,
	output logic           pop,
	input  logic [3:0]     column_count,
	input  logic           threshold_enable,
	input  logic [7:0]     threshold,
	output logic           result_valid,
	output logic [7:0]     result_value
);

	localparam int GENE_DEPTH = COLUMNS * 3 * PES_PER_COLUMN + 3;
	localparam int GA_W  = $clog2(GENE_DEPTH);
	localparam int GI_W  = (GA_W > 8) ? GA_W : 8;
	localparam int FA_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int FI_W  = (FA_W > 4) ? FA_W : 4;
	localparam int PE_W  = $clog2(PES_PER_COLUMN);
	localparam int CA_W  = PE_W + 1;
	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	epge_pkg::seq_state_t state_q, state_d;

	logic [GA_W-1:0]  gaddr_q;
	logic [COL_W-1:0] col_q;
	logic [PE_W-1:0]  elem_q;
	logic             final_q;
	logic             bank_q;
	logic [7:0]       x_q;
	logic             src_bad_q;
	logic             result_valid_q;
	logic [7:0]       result_value_q;

	logic [COL_W-1:0] last_col;
	logic             first_col;
	logic             elem_last;

	logic             gene_we;
	logic [GA_W-1:0]  gene_wa;
	logic [GI_W-1:0]  gene_wi;
	logic [3:0]       gene_rdata;
	logic             feat_we;
	logic [FA_W-1:0]  feat_ra;
	logic [FI_W-1:0]  feat_ri;
	logic [7:0]       feat_rdata;
	logic             col_we;
	logic [CA_W-1:0]  col_wa;
	logic [CA_W-1:0]  col_ra;
	logic [7:0]       col_rdata;
	logic [7:0]       src_rdata;
	logic             src_bad;
	logic [7:0]       y_val;
	logic [7:0]       op_res;
	logic [7:0]       out_val;

	// clamp column count to 1..COLUMNS, as last column index
	always_comb begin
		if (column_count == 4'd0) begin
			last_col = '0;
		end else if ({1'b0, column_count} >= 5'(COLUMNS)) begin
			last_col = COL_W'(COLUMNS - 1);
		end else begin
			last_col = COL_W'(column_count - 4'd1);
		end
	end

	assign first_col = (col_q == '0) & ~final_q;
	assign elem_last = (elem_q == PE_W'(PES_PER_COLUMN - 1));

	assign gene_wi = GI_W'(pop_word.addr);
	assign gene_wa = gene_wi[GA_W-1:0];
	assign feat_ri = FI_W'(gene_rdata);
	assign feat_ra = feat_ri[FA_W-1:0];
	assign col_ra  = {bank_q, gene_rdata[PE_W-1:0]};
	assign col_wa  = {~bank_q, elem_q};
	assign src_bad = first_col ? (int'(gene_rdata) >= FEATURES)
	                           : (int'(gene_rdata) >= PES_PER_COLUMN);
	assign src_rdata = first_col ? feat_rdata : col_rdata;
	assign y_val   = src_bad_q ? 8'd0 : src_rdata;
	assign op_res  = epge_pkg::apply_op(epge_pkg::opcode_t'(gene_rdata[2:0]), x_q, y_val);
	assign out_val = threshold_enable ? {7'd0, op_res >= threshold} : op_res;

	epge_ram #(.WIDTH(4), .DEPTH(GENE_DEPTH)) u_gene_ram (
		.clk     (clk),
		.wr_en   (gene_we),
		.wr_addr (gene_wa),
		.wr_data (pop_word.data[3:0]),
		.rd_addr (gaddr_q),
		.rd_data (gene_rdata)
	);

	epge_ram #(.WIDTH(8), .DEPTH(FEATURES)) u_feat_ram (
		.clk     (clk),
		.wr_en   (feat_we),
		.wr_addr (pop_word.addr[FA_W-1:0]),
		.wr_data (pop_word.data),
		.rd_addr (feat_ra),
		.rd_data (feat_rdata)
	);

	epge_ram #(.WIDTH(8), .DEPTH(2 * PES_PER_COLUMN)) u_col_ram (
		.clk     (clk),
		.wr_en   (col_we),
		.wr_addr (col_wa),
		.wr_data (op_res),
		.rd_addr (col_ra),
		.rd_data (col_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			epge_pkg::ST_IDLE: begin
				if (!empty && pop_word.eval) begin
					state_d = epge_pkg::ST_GX;
				end
			end
			epge_pkg::ST_GX:   state_d = epge_pkg::ST_GY;
			epge_pkg::ST_GY:   state_d = epge_pkg::ST_GOP;
			epge_pkg::ST_GOP:  state_d = epge_pkg::ST_EXEC;
			epge_pkg::ST_EXEC: state_d = final_q ? epge_pkg::ST_IDLE : epge_pkg::ST_GX;
			default:           state_d = epge_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		gene_we = 1'b0;
		feat_we = 1'b0;
		col_we  = 1'b0;
		case (state_q)
			epge_pkg::ST_IDLE: begin
				pop     = ~empty;
				gene_we = ~empty & pop_word.wr & (pop_word.kind == epge_pkg::CMD_GENE);
				feat_we = ~empty & pop_word.wr & (pop_word.kind == epge_pkg::CMD_FEATURE);
			end
			epge_pkg::ST_EXEC: begin
				col_we = ~final_q;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		src_bad_q <= src_bad;
		if (state_q == epge_pkg::ST_GOP) begin
			x_q <= src_bad_q ? 8'd0 : src_rdata;
		end
		if (state_q == epge_pkg::ST_EXEC) begin
			result_value_q <= out_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= epge_pkg::ST_IDLE;
			gaddr_q        <= '0;
			col_q          <= '0;
			elem_q         <= '0;
			final_q        <= 1'b0;
			bank_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= (state_q == epge_pkg::ST_EXEC) & final_q;
			case (state_q)
				epge_pkg::ST_IDLE: begin
					gaddr_q <= '0;
					col_q   <= '0;
					elem_q  <= '0;
					final_q <= 1'b0;
				end
				epge_pkg::ST_GX, epge_pkg::ST_GY, epge_pkg::ST_GOP: begin
					gaddr_q <= gaddr_q + 1'b1;
				end
				epge_pkg::ST_EXEC: begin
					if (final_q) begin
						final_q <= 1'b0;
					end else if (elem_last) begin
						elem_q <= '0;
						bank_q <= ~bank_q;
						if (col_q == last_col) begin
							final_q <= 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end else begin
						elem_q <= elem_q + 1'b1;
					end
				end
				default: begin
					final_q <= final_q;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result_value = result_value_q;

endmodule

@@ design/evolved_pe_grid_evaluator_core.sv @@
// Top level of the evolved PE grid evaluator: config registers, front end, queue, engine.
//
// Gene writes and feature words pass a four-word queue and are executed while the
// engine is idle. The last feature of a row starts an evaluation that steps through
// every element in use, each element passing states GX, GY, GOP and EXEC in turn
// (three gene reads from the gene RAM with its single read port, then the operator).
// busy rises only while the queue is full, so words of the next row are taken during
// an evaluation. result_valid is a single-cycle strobe and cannot be held off; the
// receiver must take it when it comes.
module evolved_pe_grid_evaluator_core #(
	parameter int FEATURES       = epge_pkg::FEATURES_DEF,
	parameter int PES_PER_COLUMN = epge_pkg::PES_DEF,
	parameter int COLUMNS        = epge_pkg::COLUMNS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           operation,
	input  logic [7:0]                     gene_index,
	input  logic [3:0]                     gene_value,
	input  logic [7:0]                     feature_value,
	input  logic                           last_feature,
	output logic                           result_valid,
	output logic [7:0]                     result_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [epge_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [epge_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [3:0]     column_count_q;
	logic           threshold_enable_q;
	logic [7:0]     threshold_q;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	epge_pkg::cmd_t q_in_word;
	epge_pkg::cmd_t q_out_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q     <= epge_pkg::COLUMN_COUNT_RST;
			threshold_enable_q <= 1'b0;
			threshold_q        <= epge_pkg::THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				epge_pkg::CFG_COLUMN_COUNT: column_count_q     <= cfg_data[3:0];
				epge_pkg::CFG_THR_ENABLE:   threshold_enable_q <= cfg_data[0];
				epge_pkg::CFG_THRESHOLD:    threshold_q        <= cfg_data[7:0];
				default:                    threshold_q        <= threshold_q;
			endcase
		end
	end

	epge_front #(
		.FEATURES   (FEATURES),
		.GENE_DEPTH (COLUMNS * 3 * PES_PER_COLUMN + 3)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.gene_index    (gene_index),
		.gene_value    (gene_value),
		.feature_value (feature_value),
		.last_feature  (last_feature),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_word        (q_in_word)
	);

	epge_queue #(.DEPTH(epge_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in_word),
		.full      (q_full),
		.pop       (q_pop),
		.pop_word  (q_out_word),
		.empty     (q_empty)
	);

	epge_back #(
		.FEATURES       (FEATURES),
		.PES_PER_COLUMN (PES_PER_COLUMN),
		.COLUMNS        (COLUMNS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_word         (q_out_word),
		.empty            (q_empty),
		.pop              (q_pop),
		.column_count     (column_count_q),
		.threshold_enable (threshold_enable_q),
		.threshold        (threshold_q),
		.result_valid     (result_valid),
		.result_value     (result_value)
	);

endmodule
